@@ hw/rtl/rc4_drop_keystream_cipher_assert.svh @@
// ----------------------------------------------------------------------------
// RC4-drop assertion macros
// Shared wrappers for the concurrent checks of the cipher block.
// ----------------------------------------------------------------------------
`ifndef RC4_DROP_KEYSTREAM_CIPHER_ASSERT_SVH
`define RC4_DROP_KEYSTREAM_CIPHER_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define RC4D_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Check a property on every clock edge, reset cycles included.
`define RC4D_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

@@ hw/rtl/rc4d_pkg.sv @@
// ----------------------------------------------------------------------------
// RC4-drop package
// Widths, register indexes, action codes and sequencer states.
// ----------------------------------------------------------------------------
package rc4d_pkg;

  localparam int TABLE_DEPTH    = 256;
  localparam int ADDR_W         = $clog2(TABLE_DEPTH);
  localparam int KEY_BYTES_MAX  = 8;
  localparam int KEY_LENGTH_DEF = 8;
  localparam int KEY_W          = 8 * KEY_BYTES_MAX;
  localparam int DROP_W         = 12;
  localparam int CFG_DATA_W     = KEY_W;

  localparam logic [DROP_W-1:0] DROP_RESET = 12'd1025;

  typedef logic [0:0] cfg_idx_t;
  localparam cfg_idx_t CFG_KEY_BYTES  = 1'b0;
  localparam cfg_idx_t CFG_DROP_COUNT = 1'b1;

  localparam logic ACT_INIT  = 1'b0;
  localparam logic ACT_CRYPT = 1'b1;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FILL,
    ST_K_RD_I,
    ST_K_RD_J,
    ST_K_WR_I,
    ST_K_WR_J,
    ST_G_RD_I,
    ST_G_RD_J,
    ST_G_WR_I,
    ST_G_WR_J,
    ST_OUT
  } state_t;

endpackage

@@ hw/rtl/rc4d_stream_if.sv @@
// ----------------------------------------------------------------------------
// RC4-drop stream channels
// Valid/ready channels for input words and result words.
// ----------------------------------------------------------------------------
interface rc4d_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] data_byte;
  logic       last_in;

  modport source (output valid, output action, output data_byte, output last_in,
                  input ready);
  modport sink   (input valid, input action, input data_byte, input last_in,
                  output ready);
endinterface

interface rc4d_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_out;

  modport source (output valid, output out_byte, output last_out, input ready);
  modport sink   (input valid, input out_byte, input last_out, output ready);
endinterface

@@ hw/rtl/rc4_drop_keystream_cipher.sv @@
// ----------------------------------------------------------------------------
// RC4-drop keystream cipher
// Key schedule, drop phase and byte crypt around one 256 x 8 permutation RAM.
// ----------------------------------------------------------------------------
// The permutation lives in a single synchronous RAM (one write, one read port,
// registered read data) and every swap is a read-read-write-write sequence
// on it, which sets the speed. An init word fills the table, runs the 256
// key schedule steps, then one swap step per dropped byte, all before the
// next word is taken. A crypt word runs one swap step, then puts its
// result in an output register, so the next word is taken while the result
// waits. Crypt words are only meaningful after an init word. The user must
// write the key and drop count registers only while the block is idle; the
// block itself does not enforce it.
module rc4_drop_keystream_cipher #(
  parameter int KEY_LENGTH = rc4d_pkg::KEY_LENGTH_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  rc4d_in_if.sink                         in_ch,
  rc4d_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  rc4d_pkg::cfg_idx_t              cfg_index,
  input  logic [rc4d_pkg::CFG_DATA_W-1:0] cfg_data
);
  import rc4d_pkg::*;

  localparam int KIDX_W = $clog2(KEY_BYTES_MAX);

  logic [7:0] mem [TABLE_DEPTH];

  state_t              state_r, state_nxt;
  logic [ADDR_W-1:0]   cnt_r, cnt_nxt;
  logic [KIDX_W-1:0]   kidx_r, kidx_nxt;
  logic [ADDR_W-1:0]   i_r, i_nxt;
  logic [ADDR_W-1:0]   j_r, j_nxt;
  logic [7:0]          si_r, si_nxt;
  logic [7:0]          sj_r, sj_nxt;
  logic                fwd_r, fwd_nxt;
  logic                crypt_r, crypt_nxt;
  logic [7:0]          data_r, data_nxt;
  logic                last_r, last_nxt;
  logic [DROP_W-1:0]   drop_left_r, drop_left_nxt;
  logic [KEY_W-1:0]    key_r, key_nxt;
  logic [DROP_W-1:0]   drop_cnt_r, drop_cnt_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic                out_last_r, out_last_nxt;
  logic [7:0]          rdata_r;

  logic                mem_we;
  logic [ADDR_W-1:0]   mem_waddr;
  logic [7:0]          mem_wdata;
  logic [ADDR_W-1:0]   mem_raddr;

  logic                in_acc;
  logic [7:0]          key_sel;
  logic [ADDR_W-1:0]   k_sum;
  logic [ADDR_W-1:0]   g_sum;
  logic [ADDR_W-1:0]   t_addr;
  logic [KIDX_W-1:0]   kidx_inc;

  assign in_ch.ready     = (state_r == ST_IDLE);
  assign in_acc          = in_ch.valid && in_ch.ready;
  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_byte = out_byte_r;
  assign out_ch.last_out = out_last_r;

  assign key_sel  = key_r[{kidx_r, 3'b000} +: 8];
  assign k_sum    = j_r + rdata_r + key_sel;
  assign g_sum    = j_r + rdata_r;
  assign t_addr   = si_r + sj_r;
  assign kidx_inc = (kidx_r == KIDX_W'(KEY_LENGTH - 1)) ? '0 : kidx_r + 1'b1;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_r <= mem[mem_raddr];
  end

  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    kidx_nxt      = kidx_r;
    i_nxt         = i_r;
    j_nxt         = j_r;
    si_nxt        = si_r;
    sj_nxt        = sj_r;
    fwd_nxt       = fwd_r;
    crypt_nxt     = crypt_r;
    data_nxt      = data_r;
    last_nxt      = last_r;
    drop_left_nxt = drop_left_r;
    key_nxt       = key_r;
    drop_cnt_nxt  = drop_cnt_r;
    out_valid_nxt = out_valid_r;
    out_byte_nxt  = out_byte_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = '0;
    mem_wdata     = '0;
    mem_raddr     = '0;

    if (cfg_we) begin
      case (cfg_index)
        CFG_KEY_BYTES:  key_nxt = cfg_data;
        CFG_DROP_COUNT: drop_cnt_nxt = cfg_data[DROP_W-1:0];
        default: ;
      endcase
    end

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_acc) begin
          if (in_ch.action == ACT_INIT) begin
            cnt_nxt   = '0;
            state_nxt = ST_FILL;
          end else begin
            crypt_nxt = 1'b1;
            data_nxt  = in_ch.data_byte;
            last_nxt  = in_ch.last_in;
            state_nxt = ST_G_RD_I;
          end
        end
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = cnt_r;
        cnt_nxt   = cnt_r + 1'b1;
        if (cnt_r == '1) begin
          j_nxt     = '0;
          kidx_nxt  = '0;
          state_nxt = ST_K_RD_I;
        end
      end
      ST_K_RD_I: begin
        mem_raddr = cnt_r;
        state_nxt = ST_K_RD_J;
      end
      ST_K_RD_J: begin
        si_nxt    = rdata_r;
        j_nxt     = k_sum;
        mem_raddr = k_sum;
        state_nxt = ST_K_WR_I;
      end
      ST_K_WR_I: begin
        mem_we    = 1'b1;
        mem_waddr = cnt_r;
        mem_wdata = rdata_r;
        state_nxt = ST_K_WR_J;
      end
      ST_K_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = si_r;
        cnt_nxt   = cnt_r + 1'b1;
        kidx_nxt  = kidx_inc;
        if (cnt_r == '1) begin
          // schedule done: reset both indices, then drop, or go idle if the drop count is zero
          i_nxt         = '0;
          j_nxt         = '0;
          crypt_nxt     = 1'b0;
          drop_left_nxt = drop_cnt_r;
          state_nxt     = (drop_cnt_r == '0) ? ST_IDLE : ST_G_RD_I;
        end else begin
          state_nxt = ST_K_RD_I;
        end
      end
      ST_G_RD_I: begin
        i_nxt     = i_r + 1'b1;
        mem_raddr = i_r + 1'b1;
        state_nxt = ST_G_RD_J;
      end
      ST_G_RD_J: begin
        si_nxt    = rdata_r;
        j_nxt     = g_sum;
        mem_raddr = g_sum;
        state_nxt = ST_G_WR_I;
      end
      ST_G_WR_I: begin
        sj_nxt    = rdata_r;
        mem_we    = 1'b1;
        mem_waddr = i_r;
        mem_wdata = rdata_r;
        state_nxt = ST_G_WR_J;
      end
      ST_G_WR_J: begin
        mem_we    = 1'b1;
        mem_waddr = j_r;
        mem_wdata = si_r;
        // keystream read collides with this write when it hits entry j
        mem_raddr = t_addr;
        fwd_nxt   = (t_addr == j_r);
        if (crypt_r) begin
          state_nxt = ST_OUT;
        end else begin
          drop_left_nxt = drop_left_r - 1'b1;
          state_nxt     = (drop_left_r == DROP_W'(1)) ? ST_IDLE : ST_G_RD_I;
        end
      end
      ST_OUT: begin
        // hold the read address so the data stays put while stalled
        mem_raddr = t_addr;
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_byte_nxt  = data_r ^ (fwd_r ? si_r : rdata_r);
          out_last_nxt  = last_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      i_r         <= '0;
      j_r         <= '0;
      key_r       <= '0;
      drop_cnt_r  <= DROP_RESET;
      out_valid_r <= 1'b0;
      crypt_r     <= 1'b0;
      drop_left_r <= '0;
      cnt_r       <= '0;
      kidx_r      <= '0;
    end else begin
      state_r     <= state_nxt;
      i_r         <= i_nxt;
      j_r         <= j_nxt;
      key_r       <= key_nxt;
      drop_cnt_r  <= drop_cnt_nxt;
      out_valid_r <= out_valid_nxt;
      crypt_r     <= crypt_nxt;
      drop_left_r <= drop_left_nxt;
      cnt_r       <= cnt_nxt;
      kidx_r      <= kidx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    si_r       <= si_nxt;
    sj_r       <= sj_nxt;
    fwd_r      <= fwd_nxt;
    data_r     <= data_nxt;
    last_r     <= last_nxt;
    out_byte_r <= out_byte_nxt;
    out_last_r <= out_last_nxt;
  end

  `include "rc4_drop_keystream_cipher_assert.svh"

  `RC4D_ASSERT(a_out_from_result_state, $rose(out_valid_r) |-> $past(state_r) == ST_OUT, "result word raised outside the result state")
  `RC4D_ASSERT(a_write_only_in_swap, mem_we |-> (state_r == ST_FILL || state_r == ST_K_WR_I || state_r == ST_K_WR_J || state_r == ST_G_WR_I || state_r == ST_G_WR_J), "table written outside fill or swap")
  `RC4D_ASSERT(a_drop_left_nonzero, (state_r == ST_G_RD_I && !crypt_r) |-> drop_left_r != '0, "drop step started with nothing left to drop")
  `RC4D_ASSERT_ALWAYS(a_reset_clears_out, !rst_n |=> !out_valid_r, "result word valid after reset")

endmodule
